>>> rtl/per_destination_send_queues_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-destination send queues
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PER_DESTINATION_SEND_QUEUES_UNIT_DEFINES_SVH
`define PER_DESTINATION_SEND_QUEUES_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset.
`define PSQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define PSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PSQ_ASSERT(lbl, clk, rst, prop, msg)
`define PSQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/psq_pkg.sv
// ----------------------------------------------------------------------------
// Send queue package
// Field widths, operation and status codes and the decision record shared by
// the send queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

   // Fixed field widths.
   localparam int DEST_W = 4;
   localparam int MSG_W  = 64;
   localparam int CNT_W  = 5;
   localparam int MASK_W = 16;

   // Destination count after reset.
   localparam logic [CNT_W-1:0] DEST_COUNT_RESET = 5'd16;

   // Item operation codes.
   typedef enum logic [0:0] {
      OP_SEND  = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DROPPED  = 2'd1,
      STATUS_BAD_DEST = 2'd2
   } status_type;

   // What the controller decided for the item in the input register.
   typedef struct packed {
      logic       link_valid;
      logic       store_write;
      logic       store_read;
      status_type status;
   } decision_type;

endpackage

`default_nettype wire

>>> rtl/psq_req_if.sv
// ----------------------------------------------------------------------------
// Send queue request channel
// Valid/ready channel carrying one send or drain item.
// ----------------------------------------------------------------------------
`default_nettype none

interface psq_req_if;
   logic                          valid;
   logic                          ready;
   psq_pkg::opcode_type           opcode;
   logic [psq_pkg::DEST_W-1:0]    dest;
   logic [psq_pkg::MSG_W-1:0]     message;
   logic                          link_ready;
   logic [psq_pkg::MASK_W-1:0]    query_mask;

   modport source (
      output valid, opcode, dest, message, link_ready, query_mask,
      input  ready
   );

   modport sink (
      input  valid, opcode, dest, message, link_ready, query_mask,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/psq_rsp_if.sv
// ----------------------------------------------------------------------------
// Send queue response channel
// Valid/ready channel carrying one result per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

interface psq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          link_valid;
   logic [psq_pkg::DEST_W-1:0]    link_dest;
   logic [psq_pkg::MSG_W-1:0]     link_message;
   psq_pkg::status_type           status;
   logic [psq_pkg::MASK_W-1:0]    nonempty_mask;

   modport source (
      output valid, link_valid, link_dest, link_message, status, nonempty_mask,
      input  ready
   );

   modport sink (
      input  valid, link_valid, link_dest, link_message, status, nonempty_mask,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/psq_store.sv
// ----------------------------------------------------------------------------
// Send queue message store
// One memory holding every queue's entries, one write or one read per cycle,
// with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic                       clock,
   input  wire logic                       write_en,
   input  wire logic                       read_en,
   input  wire logic [ADDR_W-1:0]          addr,
   input  wire logic [psq_pkg::MSG_W-1:0]  write_data,
   output logic      [psq_pkg::MSG_W-1:0]  read_data
);

   logic [psq_pkg::MSG_W-1:0] mem_ff [DEPTH];
   logic [psq_pkg::MSG_W-1:0] read_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
   end

   // Read port; the data register holds while no read is issued.
   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem_ff[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

>>> rtl/psq_ctrl.sv
// ----------------------------------------------------------------------------
// Send queue controller
// Holds the read and write pointers of every queue and decides, for the item
// in the input register, whether it bypasses, queues, drops, drains or has a bad destination.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_DESTS   = 16,
   parameter int ADDR_W      = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        commit,
   input  wire psq_pkg::opcode_type         opcode,
   input  wire logic [psq_pkg::DEST_W-1:0]  dest,
   input  wire logic                        link_ready,
   input  wire logic [psq_pkg::MASK_W-1:0]  query_mask,
   input  wire logic [psq_pkg::CNT_W-1:0]   dest_count,
   output psq_pkg::decision_type            decision,
   output logic      [ADDR_W-1:0]           store_addr,
   output logic      [psq_pkg::MASK_W-1:0]  nonempty_mask
);

   localparam int PTR_W  = $clog2(2 * QUEUE_DEPTH);
   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int DIDX_W = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
   localparam logic [PTR_W-1:0] PTR_HALF = PTR_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * QUEUE_DEPTH - 1);

   // Pointers count modulo twice the depth so full and empty differ.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_flip(input logic [PTR_W-1:0] ptr);
      return (ptr >= PTR_HALF) ? ptr - PTR_HALF : ptr + PTR_HALF;
   endfunction

   function automatic logic [IDX_W-1:0] ptr_pos(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] pos;
      pos = (ptr >= PTR_HALF) ? ptr - PTR_HALF : ptr;
      return pos[IDX_W-1:0];
   endfunction

   logic [PTR_W-1:0]          wr_ptr_ff [MAX_DESTS];
   logic [PTR_W-1:0]          rd_ptr_ff [MAX_DESTS];
   logic [PTR_W-1:0]          wr_ptr_in [MAX_DESTS];
   logic [PTR_W-1:0]          rd_ptr_in [MAX_DESTS];
   logic [psq_pkg::CNT_W-1:0] eff_count;
   logic [DIDX_W-1:0]         didx;
   logic [PTR_W-1:0]          wr_ptr;
   logic [PTR_W-1:0]          rd_ptr;
   logic                      bad_dest;
   logic                      empty;
   logic                      full;

   // Addressed queue and its state.
   assign eff_count = (dest_count > psq_pkg::CNT_W'(MAX_DESTS)) ?
                      psq_pkg::CNT_W'(MAX_DESTS) : dest_count;
   assign didx      = dest[DIDX_W-1:0];
   assign bad_dest  = {1'b0, dest} >= eff_count;
   assign wr_ptr    = wr_ptr_ff[didx];
   assign rd_ptr    = rd_ptr_ff[didx];
   assign empty     = (wr_ptr == rd_ptr);
   assign full      = (wr_ptr == ptr_flip(rd_ptr));

   // Item decision.
   always_comb begin
      decision = '{link_valid: 1'b0, store_write: 1'b0, store_read: 1'b0,
                   status: psq_pkg::STATUS_OK};
      if (bad_dest) begin
         decision.status = psq_pkg::STATUS_BAD_DEST;
      end else begin
         case (opcode)
            psq_pkg::OP_SEND: begin
               if (empty && link_ready) begin
                  decision.link_valid = 1'b1;
               end else if (full) begin
                  decision.status = psq_pkg::STATUS_DROPPED;
               end else begin
                  decision.store_write = 1'b1;
               end
            end
            psq_pkg::OP_DRAIN: begin
               if (!empty && link_ready) begin
                  decision.link_valid = 1'b1;
                  decision.store_read = 1'b1;
               end
            end
            default: begin
               decision.status = psq_pkg::STATUS_OK;
            end
         endcase
      end
   end

   // Store address: queue base plus the slot of the pointer in use.
   assign store_addr = ADDR_W'(didx) * ADDR_W'(QUEUE_DEPTH) +
                       ADDR_W'((opcode == psq_pkg::OP_SEND) ? ptr_pos(wr_ptr)
                                                            : ptr_pos(rd_ptr));

   // Pointer values after this item.
   always_comb begin
      for (int d = 0; d < MAX_DESTS; d++) begin
         wr_ptr_in[d] = wr_ptr_ff[d];
         rd_ptr_in[d] = rd_ptr_ff[d];
         if (DIDX_W'(d) == didx) begin
            if (decision.store_write) begin
               wr_ptr_in[d] = ptr_next(wr_ptr_ff[d]);
            end
            if (decision.store_read) begin
               rd_ptr_in[d] = ptr_next(rd_ptr_ff[d]);
            end
         end
      end
   end

   // Non-empty map as it stands after this item.
   always_comb begin
      nonempty_mask = '0;
      for (int d = 0; d < MAX_DESTS; d++) begin
         nonempty_mask[d] = (wr_ptr_in[d] != rd_ptr_in[d]) &&
                            (psq_pkg::CNT_W'(d) < eff_count) && query_mask[d];
      end
   end

   // Pointer registers advance when the item is committed.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DESTS; d++) begin
            wr_ptr_ff[d] <= '0;
            rd_ptr_ff[d] <= '0;
         end
      end else if (commit) begin
         for (int d = 0; d < MAX_DESTS; d++) begin
            wr_ptr_ff[d] <= wr_ptr_in[d];
            rd_ptr_ff[d] <= rd_ptr_in[d];
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/per_destination_send_queues_unit.sv
// ----------------------------------------------------------------------------
// Per-destination send queues
// One FIFO of 64-bit messages for each destination core, with bypass to the
// link when a queue is empty and the link is ready.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per transfer: a send of a message to a destination,
//   or a drain attempt of one destination's queue, with the link's readiness
//   and the mask of destinations to report. rsp returns exactly one result per
//   item: the message handed to the link (if any), a status and the masked map
//   of non-empty queues after the item. csr_write_enable loads dest_count.
//   An accepted item sits in the input register, where the pointer logic
//   decides it and the message store is written or read; its result is then
//   captured in the result register and shown on rsp. One item per cycle is
//   sustained unless rsp stalls; the single store port is used at most once per item.
//   When rsp is stalled the result holds and the input register still takes
//   one more item; req.ready falls once both stages are full.
//   Reset empties every queue and sets dest_count to 16. The message store is
//   not cleared; only queued entries are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_destination_send_queues_unit_defines.svh"

module per_destination_send_queues_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_DESTS   = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   psq_req_if.sink                         req,
   psq_rsp_if.source                       rsp,
   input  wire logic                       csr_write_enable,
   input  wire logic [psq_pkg::CNT_W-1:0]  csr_write_data
);

   localparam int STORE_DEPTH = MAX_DESTS * QUEUE_DEPTH;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [psq_pkg::CNT_W-1:0]  dest_count_ff;

   logic                       s1_valid_ff;
   psq_pkg::opcode_type        s1_opcode_ff;
   logic [psq_pkg::DEST_W-1:0] s1_dest_ff;
   logic [psq_pkg::MSG_W-1:0]  s1_message_ff;
   logic                       s1_link_ready_ff;
   logic [psq_pkg::MASK_W-1:0] s1_query_mask_ff;

   logic                       rsp_valid_ff;
   logic                       link_valid_ff;
   logic                       from_store_ff;
   logic [psq_pkg::DEST_W-1:0] link_dest_ff;
   logic [psq_pkg::MSG_W-1:0]  link_message_ff;
   psq_pkg::status_type        status_ff;
   logic [psq_pkg::MASK_W-1:0] nonempty_ff;

   psq_pkg::decision_type      decision;
   logic [ADDR_W-1:0]          store_addr;
   logic [psq_pkg::MASK_W-1:0] nonempty_mask;
   logic [psq_pkg::MSG_W-1:0]  store_data;
   logic                       out_open;
   logic                       commit;
   logic                       req_take;

   // Handshake: the result register frees when empty or taken.
   assign out_open  = !rsp_valid_ff || rsp.ready;
   assign commit    = s1_valid_ff && out_open;
   assign req.ready = !s1_valid_ff || out_open;
   assign req_take  = req.valid && req.ready;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_count_ff <= psq_pkg::DEST_COUNT_RESET;
      end else if (csr_write_enable) begin
         dest_count_ff <= csr_write_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff     <= req.opcode;
         s1_dest_ff       <= req.dest;
         s1_message_ff    <= req.message;
         s1_link_ready_ff <= req.link_ready;
         s1_query_mask_ff <= req.query_mask;
      end
   end

   // Queue pointers and item decision.
   psq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_DESTS   (MAX_DESTS),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .commit        (commit),
      .opcode        (s1_opcode_ff),
      .dest          (s1_dest_ff),
      .link_ready    (s1_link_ready_ff),
      .query_mask    (s1_query_mask_ff),
      .dest_count    (dest_count_ff),
      .decision      (decision),
      .store_addr    (store_addr),
      .nonempty_mask (nonempty_mask)
   );

   // Message store; its read register feeds drained messages to rsp.
   psq_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .write_en   (commit && decision.store_write),
      .read_en    (commit && decision.store_read),
      .addr       (store_addr),
      .write_data (s1_message_ff),
      .read_data  (store_data)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         link_valid_ff   <= decision.link_valid;
         from_store_ff   <= decision.store_read;
         link_dest_ff    <= decision.link_valid ? s1_dest_ff : '0;
         link_message_ff <= (decision.link_valid && !decision.store_read) ?
                            s1_message_ff : '0;
         status_ff       <= decision.status;
         nonempty_ff     <= nonempty_mask;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.link_valid    = link_valid_ff;
   assign rsp.link_dest     = link_dest_ff;
   assign rsp.link_message  = from_store_ff ? store_data : link_message_ff;
   assign rsp.status        = status_ff;
   assign rsp.nonempty_mask = nonempty_ff;

   // A result only appears after an item sat in the input register.
   `PSQ_ASSERT(a_rsp_from_s1, clock, reset, $rose(rsp_valid_ff) |-> $past(s1_valid_ff), "result without item")

   // A message read from the store always goes out as a link transfer.
   `PSQ_ASSERT(a_store_is_link, clock, reset, (rsp_valid_ff && from_store_ff) |-> link_valid_ff, "store read without link")

   // A stalled drained message must not change under the receiver.
   `PSQ_ASSERT(a_store_hold, clock, reset, (rsp_valid_ff && from_store_ff && !rsp.ready) |=> $stable(rsp.link_message), "drained message changed while stalled")

   // Nothing reaches the result register during reset.
   `PSQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid_ff && !s1_valid_ff, "pipeline busy after reset")

endmodule

`default_nettype wire
